### design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers. In synthesis builds they are empty.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// antecedent holds -> consequent holds in the same cycle
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent holds -> consequent holds in the next cycle
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### design/b64e_pkg.sv
// ----------------------------------------------------------------------------
// b64e_pkg
// Types, alphabets and pad codes shared by the Base64 encoder modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b64e_pkg;

    typedef enum logic
    {
        ALPHA_STD    = 1'b0,
        ALPHA_CUSTOM = 1'b1
    } alphabet_t;

    localparam logic [7:0] PAD_STD    = 8'h3D;  // '='
    localparam logic [7:0] PAD_CUSTOM = 8'h23;  // '#'

    // First character sits in the top byte.
    localparam logic [511:0] STD_ALPHA =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
    // Custom set as ASCII codes, eight characters per word.
    localparam logic [511:0] CUSTOM_ALPHA =
    {
        64'h5469_6765_725F_7875,
        64'h3139_3834_3230_3662,
        64'h7A23_3525_3324_5777,
        64'h7049_5137_2A26_5B2C,
        64'h5D6D_4E6F_5945_7340,
        64'h2158_5548_4261_5A43,
        64'h7152_744F_6344_3C66,
        64'h4746_2B3E_2E68_6A4A
    };

    // One encoded group: 24 bits of data, number of trailing pads, end of message.
    typedef struct packed
    {
        logic [23:0] group;
        logic [1:0]  pad_count;
        logic        last_group;
    } group_entry_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

    function automatic logic [7:0] map_char(alphabet_t sel, logic [5:0] sym);
        logic [8:0] bit_pos;
        logic [7:0] ch;
        bit_pos = {~sym, 3'b000};
        if (sel == ALPHA_CUSTOM)
        begin
            ch = CUSTOM_ALPHA[bit_pos +: 8];
        end
        else
        begin
            ch = STD_ALPHA[bit_pos +: 8];
        end
        return ch;
    endfunction

    function automatic logic [7:0] pad_char(alphabet_t sel);
        return (sel == ALPHA_CUSTOM) ? PAD_CUSTOM : PAD_STD;
    endfunction

endpackage

### design/b64e_front.sv
// ----------------------------------------------------------------------------
// b64e_front
// Collects input bytes into groups of three and queues finished groups.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [7:0]            data_byte,
    input  logic                  last_byte,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  b64e_pkg::queue_status_t q_status,
    output logic                  push,
    output b64e_pkg::group_entry_t push_entry
);

    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic [1:0]  held_count_reg;
    logic [1:0]  held_count_next;
    logic        accept;

    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && ((held_count_reg == 2'd2) || last_byte);

    always_comb
    begin
        held_bytes_next = held_bytes_reg;
        held_count_next = held_count_reg;
        push_entry      = '0;

        case (held_count_reg)
            2'd2:
            begin
                push_entry.group     = {held_bytes_reg, data_byte};
                push_entry.pad_count = 2'd0;
            end
            2'd1:
            begin
                push_entry.group     = {held_bytes_reg[7:0], data_byte, 8'h00};
                push_entry.pad_count = 2'd1;
            end
            default:
            begin
                push_entry.group     = {data_byte, 16'h0000};
                push_entry.pad_count = 2'd2;
            end
        endcase
        push_entry.last_group = last_byte;

        if (accept)
        begin
            if (push)
            begin
                held_bytes_next = '0;
                held_count_next = 2'd0;
            end
            else
            begin
                held_bytes_next = {held_bytes_reg[7:0], data_byte};
                held_count_next = held_count_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_bytes_reg <= '0;
            held_count_reg <= 2'd0;
        end
        else
        begin
            held_bytes_reg <= held_bytes_next;
            held_count_reg <= held_count_next;
        end
    end

endmodule

### design/b64e_queue.sv
// ----------------------------------------------------------------------------
// b64e_queue
// Small FIFO of encoded groups between the front and back ends.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_queue
#(
    parameter int DEPTH = 2
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  b64e_pkg::group_entry_t push_entry,
    input  logic                   pop,
    output b64e_pkg::group_entry_t head_entry,
    output b64e_pkg::queue_status_t status
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    b64e_pkg::group_entry_t entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign head_entry   = entries_reg[rd_ptr_reg];
    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

### design/b64e_back.sv
// ----------------------------------------------------------------------------
// b64e_back
// Turns one queued group into four characters, one per accepted output word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b64e_back
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  b64e_pkg::alphabet_t     alphabet_select,
    input  b64e_pkg::group_entry_t  head_entry,
    input  b64e_pkg::queue_status_t q_status,
    output logic                    pop,
    output logic [7:0]              code_char,
    output logic                    last_char,
    output logic                    out_valid,
    input  logic                    out_ready
);

    b64e_pkg::group_entry_t entry_reg;
    logic       busy_reg;
    logic       busy_next;
    logic [1:0] char_idx_reg;
    logic [1:0] char_idx_next;
    logic       out_accept;
    logic       final_char;
    logic [5:0] sym;
    logic       is_pad;

    assign out_valid  = busy_reg;
    assign out_accept = busy_reg && out_ready;
    assign final_char = (char_idx_reg == 2'd3);
    // refill on the same edge the fourth character leaves
    assign pop        = !q_status.empty && (!busy_reg || (out_accept && final_char));

    always_comb
    begin
        case (char_idx_reg)
            2'd0:    sym = entry_reg.group[23:18];
            2'd1:    sym = entry_reg.group[17:12];
            2'd2:    sym = entry_reg.group[11:6];
            default: sym = entry_reg.group[5:0];
        endcase
        is_pad = ((char_idx_reg == 2'd3) && (entry_reg.pad_count != 2'd0))
              || ((char_idx_reg == 2'd2) && (entry_reg.pad_count == 2'd2));
        code_char = is_pad ? b64e_pkg::pad_char(alphabet_select)
                           : b64e_pkg::map_char(alphabet_select, sym);
        last_char = entry_reg.last_group && final_char;
    end

    always_comb
    begin
        busy_next     = busy_reg;
        char_idx_next = char_idx_reg;
        if (pop)
        begin
            busy_next     = 1'b1;
            char_idx_next = 2'd0;
        end
        else if (out_accept)
        begin
            if (final_char)
            begin
                busy_next = 1'b0;
            end
            char_idx_next = char_idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            entry_reg <= head_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            char_idx_reg <= 2'd0;
        end
        else
        begin
            busy_reg     <= busy_next;
            char_idx_reg <= char_idx_next;
        end
    end

endmodule

### design/base64_encoder_two_alphabets.sv
// A byte that closes a group is written into the group queue, then into the back end's
// group register before its first character shows. The back end gives one character per
// cycle while out_ready is high and a group waits; each group, full or partial, gives
// four characters. The group queue lets input run ahead by QUEUE_DEPTH groups.
// Reset (rst_n, async, active low) empties the queue and selects the standard alphabet.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// ----------------------------------------------------------------------------
// base64_encoder_two_alphabets
// Streaming Base64 encoder with a standard and a custom alphabet.
// ----------------------------------------------------------------------------
module base64_encoder_two_alphabets
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_wdata,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       in_valid,
    output logic       in_ready,
    output logic [7:0] code_char,
    output logic       last_char,
    output logic       out_valid,
    input  logic       out_ready
);

    b64e_pkg::alphabet_t     alphabet_select_reg;
    b64e_pkg::group_entry_t  push_entry;
    b64e_pkg::group_entry_t  head_entry;
    b64e_pkg::queue_status_t q_status;
    logic                    push;
    logic                    pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alphabet_select_reg <= b64e_pkg::ALPHA_STD;
        end
        else if (cfg_we)
        begin
            alphabet_select_reg <= b64e_pkg::alphabet_t'(cfg_wdata[0]);
        end
    end

    b64e_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .data_byte  (data_byte),
        .last_byte  (last_byte),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .q_status   (q_status),
        .push       (push),
        .push_entry (push_entry)
    );

    b64e_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .status     (q_status)
    );

    b64e_back u_back
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .alphabet_select (alphabet_select_reg),
        .head_entry      (head_entry),
        .q_status        (q_status),
        .pop             (pop),
        .code_char       (code_char),
        .last_char       (last_char),
        .out_valid       (out_valid),
        .out_ready       (out_ready)
    );

    `ASSERT_SAME(a_no_push_when_full, clk, rst_n, push, !q_status.full)
    `ASSERT_SAME(a_no_pop_when_empty, clk, rst_n, pop, !q_status.empty)
    `ASSERT_NEXT(a_final_byte_queued, clk, rst_n, in_valid && in_ready && last_byte, !q_status.empty)

endmodule

### test/base64_encoder_two_alphabets_checker.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// base64_encoder_two_alphabets_checker
// Watches the byte and character channels of the encoder. It tracks the open
// group and the selected alphabet, predicts the characters that each accepted
// byte causes, and compares every accepted character against the oldest one
// predicted.
// ----------------------------------------------------------------------------
module base64_encoder_two_alphabets_checker
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [0:0] cfg_wdata,
    input  logic [7:0] data_byte,
    input  logic       last_byte,
    input  logic       in_valid,
    input  logic       in_ready,
    input  logic [7:0] code_char,
    input  logic       last_char,
    input  logic       out_valid,
    input  logic       out_ready,
    output int         fail_count,
    output int         pending_chars
);

    localparam logic [7:0] EQ_PAD   = 8'h3D;
    localparam logic [7:0] HASH_PAD = 8'h23;

    // custom set as ASCII codes, first character in the top byte
    localparam logic [511:0] ALT_SET =
    {
        64'h5469_6765_725F_7875,
        64'h3139_3834_3230_3662,
        64'h7A23_3525_3324_5777,
        64'h7049_5137_2A26_5B2C,
        64'h5D6D_4E6F_5945_7340,
        64'h2158_5548_4261_5A43,
        64'h7152_744F_6344_3C66,
        64'h4746_2B3E_2E68_6A4A
    };

    typedef struct packed
    {
        logic [7:0] ch;
        logic       fin;
    } enc_char_t;

    string std_set = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    enc_char_t             char_q[$];
    b64e_pkg::alphabet_t   alpha_sel;
    logic [15:0]           open_bytes;
    logic [1:0]            open_cnt;

    function automatic logic [7:0] symbol_char(logic [5:0] sym);
        return (alpha_sel == b64e_pkg::ALPHA_CUSTOM) ? ALT_SET[(63 - sym) * 8 +: 8]
                                                     : 8'(std_set[sym]);
    endfunction

    // Symbols go out most significant first; slots past nsym carry the pad.
    task automatic queue_group(logic [23:0] grp, int nsym, logic fin);
        enc_char_t c;
        for (int k = 0; k < 4; k++)
        begin
            if (k < nsym)
            begin
                c.ch = symbol_char(6'(grp >> (18 - 6 * k)));
            end
            else
            begin
                c.ch = (alpha_sel == b64e_pkg::ALPHA_CUSTOM) ? HASH_PAD : EQ_PAD;
            end
            c.fin = fin && (k == 3);
            char_q.push_back(c);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        enc_char_t exp_c;
        if (!rst_n)
        begin
            alpha_sel  = b64e_pkg::ALPHA_STD;
            open_bytes = '0;
            open_cnt   = '0;
            char_q.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                alpha_sel = b64e_pkg::alphabet_t'(cfg_wdata[0]);
            end

            // pop before push: a word accepted on this edge can't be out yet
            if (out_valid && out_ready)
            begin
                if (char_q.size() == 0)
                begin
                    $display("%0t: unexpected char %h last %b", $time, code_char, last_char);
                    fail_count++;
                end
                else
                begin
                    exp_c = char_q.pop_front();
                    if (code_char !== exp_c.ch)
                    begin
                        $display("%0t: code_char expected %h actual %h",
                                 $time, exp_c.ch, code_char);
                        fail_count++;
                    end
                    if (last_char !== exp_c.fin)
                    begin
                        $display("%0t: last_char expected %b actual %b",
                                 $time, exp_c.fin, last_char);
                        fail_count++;
                    end
                end
            end

            if (in_valid && in_ready)
            begin
                if (open_cnt == 2'd2)
                begin
                    queue_group({open_bytes, data_byte}, 4, last_byte);
                    open_bytes = '0;
                    open_cnt   = '0;
                end
                else if (last_byte)
                begin
                    if (open_cnt == 2'd0)
                    begin
                        queue_group({data_byte, 16'h0000}, 2, 1'b1);
                    end
                    else
                    begin
                        queue_group({open_bytes[7:0], data_byte, 8'h00}, 3, 1'b1);
                    end
                    open_bytes = '0;
                    open_cnt   = '0;
                end
                else
                begin
                    open_bytes = {open_bytes[7:0], data_byte};
                    open_cnt   = open_cnt + 2'd1;
                end
            end
        end
        pending_chars = char_q.size();
    end

endmodule

### test/base64_encoder_two_alphabets_test.sv
`timescale 1ns / 1ps

// ----------------------------------------------------------------------------
// base64_encoder_two_alphabets_test
// Drives byte messages into the encoder under both alphabets: directed corner
// cases, then random messages; in the first two random phases both channels
// stall at random. A checker beside the encoder predicts and compares chars.
// ----------------------------------------------------------------------------
module base64_encoder_two_alphabets_test;

    localparam int SETTLE_CYCLES = 8;

    logic       clk       = 1'b0;
    logic       rst_n     = 1'b0;
    logic       cfg_we    = 1'b0;
    logic [0:0] cfg_wdata = 1'b0;
    logic [7:0] data_byte = 8'h00;
    logic       last_byte = 1'b0;
    logic       in_valid  = 1'b0;
    logic       out_ready = 1'b0;
    logic       in_ready;
    logic [7:0] code_char;
    logic       last_char;
    logic       out_valid;
    int         fail_count;
    int         pending_chars;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int bytes_sent    = 0;

    base64_encoder_two_alphabets u_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .code_char (code_char),
        .last_char (last_char),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    base64_encoder_two_alphabets_checker u_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .data_byte     (data_byte),
        .last_byte     (last_byte),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code_char     (code_char),
        .last_char     (last_char),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .fail_count    (fail_count),
        .pending_chars (pending_chars)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic send_byte(input logic [7:0] b, input logic fin);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        data_byte <= b;
        last_byte <= fin;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        bytes_sent++;
    endtask

    // Hold off input until every predicted char is out and the pipe is quiet.
    task automatic settle();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending_chars != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_alphabet(input b64e_pkg::alphabet_t sel);
        settle();
        cfg_wdata <= sel;
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_message(input int len);
        int         r;
        logic [7:0] b;
        for (int i = 0; i < len; i++)
        begin
            r = $urandom_range(9);
            if (r == 0)
            begin
                b = 8'h00;
            end
            else if (r == 1)
            begin
                b = 8'hFF;
            end
            else
            begin
                b = 8'($urandom_range(255));
            end
            send_byte(b, i == len - 1);
        end
    endtask

    task automatic run_phase(input int s_idle, input int r_idle, input int count,
                             input bit cfg_changes);
        int stop_at;
        int r;
        int len;
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        stop_at       = bytes_sent + count;
        while (bytes_sent < stop_at)
        begin
            if (cfg_changes && $urandom_range(7) == 0)
            begin
                set_alphabet(b64e_pkg::alphabet_t'($urandom_range(1)));
            end
            r = $urandom_range(99);
            if (r < 70)
            begin
                len = $urandom_range(6, 1);
            end
            else if (r < 95)
            begin
                len = $urandom_range(20, 7);
            end
            else
            begin
                len = $urandom_range(40, 21);
            end
            send_message(len);
        end
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // standard alphabet: one-byte and two-byte tails, full groups, all-ones
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hAA, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b0);
        send_byte(8'h04, 1'b1);

        // custom alphabet; 0x44 gives symbol 17, which is the pad char itself
        set_alphabet(b64e_pkg::ALPHA_CUSTOM);
        send_byte(8'h44, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b1);

        // alphabet switch with a byte held in the open group
        send_byte(8'h55, 1'b0);
        set_alphabet(b64e_pkg::ALPHA_STD);
        send_byte(8'h66, 1'b1);

        set_alphabet(b64e_pkg::ALPHA_CUSTOM);
        run_phase(11, 85, 147, 1'b0);
        set_alphabet(b64e_pkg::ALPHA_STD);
        run_phase(85, 11, 147, 1'b0);
        run_phase(0, 0, 150, 1'b1);

        settle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
